### src/htw_pkg.sv
// Shared types and codes for the hashed timing wheel.
`timescale 1ns / 1ps
`default_nettype none
package htw_pkg;

  localparam int ID_W     = 4;
  localparam int ID_SPACE = 16;
  localparam int PERIOD_W = 16;
  localparam int KIND_W   = 3;

  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_ADD  = 2'd1;
  localparam logic [1:0] FN_DEL  = 2'd2;

  localparam logic [KIND_W-1:0] K_EXPIRED   = 3'd0;
  localparam logic [KIND_W-1:0] K_ADDED     = 3'd1;
  localparam logic [KIND_W-1:0] K_ADD_REJ   = 3'd2;
  localparam logic [KIND_W-1:0] K_DELETED   = 3'd3;
  localparam logic [KIND_W-1:0] K_NOT_FOUND = 3'd4;
  localparam logic [KIND_W-1:0] K_NO_EXPIRY = 3'd5;

  typedef struct packed {
    logic [1:0]          func;
    logic [ID_W-1:0]     task_id;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   task_id_res;
    logic              last;
  } rsp_t;

endpackage
`default_nettype wire

### src/htw_div.sv
// Reciprocal-multiply divider by the slot count; product and result are both registered.
`timescale 1ns / 1ps
`default_nettype none
module htw_div #(
  parameter int WHEEL_SLOTS = 10
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  input  wire logic [htw_pkg::PERIOD_W-1:0]         dividend,
  output logic                                      done,
  output logic [htw_pkg::PERIOD_W-1:0]              quot,
  output logic [$clog2(WHEEL_SLOTS)-1:0]            rem
);
  import htw_pkg::*;

  localparam int SW = $clog2(WHEEL_SLOTS);
  localparam int SH = PERIOD_W + SW;
  localparam int PW = 2 * PERIOD_W + 1;
  // ceil(2^SH / slots): exact quotient for every dividend of PERIOD_W bits
  localparam logic [PERIOD_W:0] RECIP =
    (PERIOD_W+1)'(((1 << SH) + WHEEL_SLOTS - 1) / WHEEL_SLOTS);
  localparam logic [PERIOD_W-1:0] DIVISOR = PERIOD_W'(WHEEL_SLOTS);

  logic                busy;
  logic [PW-1:0]       prod;
  logic [PERIOD_W-1:0] num;
  logic [PERIOD_W-1:0] q_est;
  logic [PERIOD_W-1:0] back;
  logic [PERIOD_W-1:0] diff;

  assign q_est = PERIOD_W'(prod[PW-1:SH]);
  assign back  = q_est * DIVISOR;
  assign diff  = num - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= start;
      done <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod <= PW'(dividend) * PW'(RECIP);
      num  <= dividend;
    end
    if (busy) begin
      quot <= q_est;
      rem  <= diff[SW-1:0];
    end
  end

endmodule
`default_nettype wire

### src/hashed_timing_wheel.sv
// Hashed timing wheel of periodic tasks with round counts.
//
// Request channel req (req_valid / req_stall) carries tick, add and delete
// commands; response channel rsp (rsp_valid / rsp_stall) returns results.
// One request is taken at a time; req_stall is high while it is in work.
// Delete and rejected add: the result is loaded into the output register
// from the response state, after which the next request can be taken.
// Add: the reciprocal divider splits period - 1 into rounds and slot
// offset, the entry is written, then the result is loaded.
// Tick: the entry table is walked one entry per cycle while the walk is
// not held (MAX_TASKS capped at 16 entries), then a flush state closes it.
// Expiries leave in ascending id order, the last carrying last = 1; a
// tick with no expiry gives one result of kind "no expiry".
// Results sit in an output register; while rsp_stall is high the walk waits
// only when a further expiry must be queued, so nothing is dropped.
// Reset clears all valid bits and the current slot; entry payloads are not
// cleared and are read only once written.
`timescale 1ns / 1ps
`default_nettype none
module hashed_timing_wheel #(
  parameter int MAX_TASKS   = 16,
  parameter int WHEEL_SLOTS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire htw_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output htw_pkg::rsp_t      rsp
);
  import htw_pkg::*;

  localparam int NUM_ENTRIES = (MAX_TASKS < ID_SPACE) ? MAX_TASKS : ID_SPACE;
  localparam int IW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int SW = $clog2(WHEEL_SLOTS);
  localparam int RW = $clog2(((1 << PERIOD_W) - 2) / WHEEL_SLOTS + 1);
  localparam logic [SW:0]   WV       = (SW+1)'(WHEEL_SLOTS);
  localparam logic [SW-1:0] SLOT_TOP = SW'(WHEEL_SLOTS - 1);
  localparam logic [ID_W:0] ID_LIM   = (ID_W+1)'(NUM_ENTRIES);
  localparam logic [IW-1:0] IDX_LAST = IW'(NUM_ENTRIES - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_RESP  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;

  logic [2:0]              state;
  logic [SW-1:0]           cur;
  logic [IW-1:0]           widx;
  logic [IW-1:0]           pend;
  logic                    have_pend;
  logic [ID_W-1:0]         op_id;
  logic [KIND_W-1:0]       op_kind;

  logic [NUM_ENTRIES-1:0]  entry_valid;
  logic [SW-1:0]           entry_slot   [NUM_ENTRIES];
  logic [SW-1:0]           entry_rem    [NUM_ENTRIES];
  logic [RW-1:0]           entry_rounds [NUM_ENTRIES];
  logic [RW-1:0]           entry_reload [NUM_ENTRIES];

  logic                    can_load;
  logic                    rsp_load;
  logic                    id_ok;
  logic [IW-1:0]           id_ix;
  logic [IW-1:0]           op_ix;
  logic                    add_rej;
  logic                    div_start;
  logic                    div_done;
  logic [PERIOD_W-1:0]     div_quot;
  logic [SW-1:0]           div_rem;
  logic                    w_hit;
  logic                    w_expire;
  logic                    walk_go;

  function automatic logic [SW-1:0] wrap_slot(input logic [SW-1:0] r, input logic [SW-1:0] c);
    logic [SW:0] s;
    s = {1'b0, r} + {1'b0, c} + (SW+1)'(1);
    if (s >= WV) s = s - WV;
    return s[SW-1:0];
  endfunction

  assign req_stall = state != S_IDLE;
  assign can_load  = !rsp_valid || !rsp_stall;
  assign id_ok     = {1'b0, req.task_id} < ID_LIM;
  assign id_ix     = req.task_id[IW-1:0];
  assign op_ix     = op_id[IW-1:0];
  assign add_rej   = (req.period == '0) || !id_ok || entry_valid[id_ix];
  assign div_start = (state == S_IDLE) && req_valid && (req.func == FN_ADD) && !add_rej;

  assign w_hit    = entry_valid[widx] && (entry_slot[widx] == cur);
  assign w_expire = w_hit && (entry_rounds[widx] == '0);
  assign walk_go  = !(w_expire && have_pend && !can_load);
  assign rsp_load = ((state == S_RESP || state == S_FLUSH) && can_load) ||
                    (state == S_WALK && walk_go && w_expire && have_pend);

  htw_div #(
    .WHEEL_SLOTS(WHEEL_SLOTS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.period - PERIOD_W'(1)),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cur         <= '0;
      rsp_valid   <= 1'b0;
      have_pend   <= 1'b0;
      entry_valid <= '0;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_id <= req.task_id;
            case (req.func)
              FN_ADD: begin
                if (add_rej) begin
                  op_kind <= K_ADD_REJ;
                  state   <= S_RESP;
                end else begin
                  state <= S_DIV;
                end
              end
              FN_DEL: begin
                if (id_ok && entry_valid[id_ix]) begin
                  entry_valid[id_ix] <= 1'b0;
                  op_kind            <= K_DELETED;
                end else begin
                  op_kind <= K_NOT_FOUND;
                end
                state <= S_RESP;
              end
              FN_TICK: begin
                cur       <= (cur == SLOT_TOP) ? '0 : cur + SW'(1);
                widx      <= '0;
                have_pend <= 1'b0;
                state     <= S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_DIV: begin
          if (div_done) begin
            entry_valid[op_ix] <= 1'b1;
            op_kind            <= K_ADDED;
            state              <= S_RESP;
          end
        end
        S_RESP: begin
          if (can_load) begin
            rsp   <= '{kind: op_kind, task_id_res: op_id, last: 1'b1};
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          if (walk_go) begin
            if (w_expire) begin
              if (have_pend) begin
                rsp <= '{kind: K_EXPIRED, task_id_res: ID_W'(pend), last: 1'b0};
              end
              pend      <= widx;
              have_pend <= 1'b1;
            end
            if (widx == IDX_LAST) state <= S_FLUSH;
            else widx <= widx + IW'(1);
          end
        end
        S_FLUSH: begin
          if (can_load) begin
            if (have_pend) rsp <= '{kind: K_EXPIRED, task_id_res: ID_W'(pend), last: 1'b1};
            else rsp <= '{kind: K_NO_EXPIRY, task_id_res: '0, last: 1'b1};
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      entry_rounds[op_ix] <= div_quot[RW-1:0];
      entry_reload[op_ix] <= div_quot[RW-1:0];
      entry_rem[op_ix]    <= div_rem;
      entry_slot[op_ix]   <= wrap_slot(div_rem, cur);
    end else if (state == S_WALK && walk_go) begin
      if (w_expire) begin
        entry_slot[widx]   <= wrap_slot(entry_rem[widx], cur);
        entry_rounds[widx] <= entry_reload[widx];
      end else if (w_hit) begin
        entry_rounds[widx] <= entry_rounds[widx] - RW'(1);
      end
    end
  end

  a_div_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside an add");

  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    cur <= SLOT_TOP)
    else $error("current slot out of range");

  a_not_last_expiry: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.kind == K_EXPIRED)
    else $error("non-final result that is not an expiry");

  a_pend_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && $past(state) == S_IDLE |-> !have_pend)
    else $error("stale pending expiry at start of tick");

endmodule
`default_nettype wire
